/* src/rmfb_pkg.sv */
// Shared types, constants and codes of the rotated monochrome framebuffer blitter.
`default_nettype none

package rmfb_pkg;

    // Default geometry, handed to the top level parameters.
    localparam int LOGICAL_WIDTH_DEF  = 250;
    localparam int LOGICAL_HEIGHT_DEF = 122;
    localparam int PANEL_WIDTH_DEF    = 122;
    localparam int PANEL_HEIGHT_DEF   = 250;

    // Working width of logical coordinates: covers a scaled bitmap far off panel.
    localparam int COORD_W = 14;

    localparam logic [7:0] PIX_MASK_MSB = 8'h80;
    localparam logic [7:0] BYTE_WHITE   = 8'hFF;
    localparam logic [2:0] LAST_BIT     = 3'd7;

    localparam int TDATA_IN_W  = 80;
    localparam int TUSER_IN_W  = 3;
    localparam int TDATA_OUT_W = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_PIXEL  = 3'd1,
        ACT_RECT   = 3'd2,
        ACT_BITMAP = 3'd3,
        ACT_READ   = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_SIZE     = 2'd2,
        CFG_SCALE    = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPAN_LOAD,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_BIT,
        ST_RD_ISSUE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [10:0] pos_x;
        logic signed [10:0] pos_y;
        logic [8:0]         rect_width;
        logic [8:0]         rect_height;
        logic               ink_black;
        logic [7:0]         source_byte;
        logic [7:0]         source_row;
        logic [4:0]         source_column;
        logic [11:0]        read_index;
    } item_t;

    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic span_load_item;
        logic span_load_square;
        logic span_step;
        logic pix_rd;
        logic pix_wr;
        logic bit_step;
        logic rd_issue;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic span_empty;
        logic span_last;
        logic pix_in_clip;
        logic bit_paints;
        logic bit_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* src/rmfb_ctrl.sv */
// Controller state machine of the framebuffer blitter.
`default_nettype none

module rmfb_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [2:0]         in_action,
    output logic                    in_ready,
    input  wire rmfb_pkg::dp_status_t status,
    output rmfb_pkg::ctrl_cmd_t     cmd
);

    rmfb_pkg::state_t state_reg, state_next;
    logic bitmap_reg, bitmap_next;
    logic clr_item_reg, clr_item_next;
    logic accept;
    rmfb_pkg::state_t span_end_state;

    assign in_ready = (state_reg == rmfb_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Where a finished span goes: next bitmap bit or the result.
    always_comb
    begin
        if (bitmap_reg && !status.bit_last)
        begin
            span_end_state = rmfb_pkg::ST_BIT;
        end
        else
        begin
            span_end_state = rmfb_pkg::ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rmfb_pkg::ST_CLEAR;
            bitmap_reg   <= 1'b0;
            clr_item_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bitmap_reg   <= bitmap_next;
            clr_item_reg <= clr_item_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next    = state_reg;
        bitmap_next   = bitmap_reg;
        clr_item_next = clr_item_reg;
        case (state_reg)
            rmfb_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = clr_item_reg ? rmfb_pkg::ST_DONE : rmfb_pkg::ST_IDLE;
                end
            end
            rmfb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    bitmap_next   = 1'b0;
                    clr_item_next = 1'b0;
                    case (rmfb_pkg::action_t'(in_action))
                        rmfb_pkg::ACT_CLEAR:
                        begin
                            clr_item_next = 1'b1;
                            state_next    = rmfb_pkg::ST_CLEAR;
                        end
                        rmfb_pkg::ACT_PIXEL:  state_next = rmfb_pkg::ST_SPAN_LOAD;
                        rmfb_pkg::ACT_RECT:   state_next = rmfb_pkg::ST_SPAN_LOAD;
                        rmfb_pkg::ACT_BITMAP:
                        begin
                            bitmap_next = 1'b1;
                            state_next  = rmfb_pkg::ST_BIT;
                        end
                        rmfb_pkg::ACT_READ:   state_next = rmfb_pkg::ST_RD_ISSUE;
                        default:              state_next = rmfb_pkg::ST_DONE;
                    endcase
                end
            end
            rmfb_pkg::ST_SPAN_LOAD:
            begin
                state_next = rmfb_pkg::ST_PIX_RD;
            end
            rmfb_pkg::ST_PIX_RD:
            begin
                if (status.span_empty)
                begin
                    state_next = span_end_state;
                end
                else if (status.pix_in_clip)
                begin
                    state_next = rmfb_pkg::ST_PIX_WR;
                end
                else if (status.span_last)
                begin
                    state_next = span_end_state;
                end
            end
            rmfb_pkg::ST_PIX_WR:
            begin
                state_next = status.span_last ? span_end_state : rmfb_pkg::ST_PIX_RD;
            end
            rmfb_pkg::ST_BIT:
            begin
                if (status.bit_paints)
                begin
                    state_next = rmfb_pkg::ST_PIX_RD;
                end
                else if (status.bit_last)
                begin
                    state_next = rmfb_pkg::ST_DONE;
                end
            end
            rmfb_pkg::ST_RD_ISSUE:
            begin
                state_next = rmfb_pkg::ST_DONE;
            end
            rmfb_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = rmfb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmfb_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd         = '0;
        cmd.capture = accept;
        case (state_reg)
            rmfb_pkg::ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
            end
            rmfb_pkg::ST_SPAN_LOAD:
            begin
                cmd.span_load_item = 1'b1;
            end
            rmfb_pkg::ST_PIX_RD:
            begin
                if (status.span_empty)
                begin
                    cmd.bit_step = bitmap_reg && !status.bit_last;
                end
                else if (status.pix_in_clip)
                begin
                    cmd.pix_rd = 1'b1;
                end
                else if (status.span_last)
                begin
                    cmd.bit_step = bitmap_reg && !status.bit_last;
                end
                else
                begin
                    cmd.span_step = 1'b1;
                end
            end
            rmfb_pkg::ST_PIX_WR:
            begin
                cmd.pix_wr = 1'b1;
                if (status.span_last)
                begin
                    cmd.bit_step = bitmap_reg && !status.bit_last;
                end
                else
                begin
                    cmd.span_step = 1'b1;
                end
            end
            rmfb_pkg::ST_BIT:
            begin
                if (status.bit_paints)
                begin
                    cmd.span_load_square = 1'b1;
                end
                else if (!status.bit_last)
                begin
                    cmd.bit_step = 1'b1;
                end
            end
            rmfb_pkg::ST_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
            end
            rmfb_pkg::ST_DONE:
            begin
                cmd.load_result = status.out_free;
            end
            default:
            begin
                cmd.capture = accept;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/rmfb_datapath.sv */
// Datapath of the framebuffer blitter: frame memory, pixel walker, bitmap unit, result register.
`default_nettype none

module rmfb_datapath
#(
    parameter int LOGICAL_WIDTH  = rmfb_pkg::LOGICAL_WIDTH_DEF,
    parameter int LOGICAL_HEIGHT = rmfb_pkg::LOGICAL_HEIGHT_DEF,
    parameter int PANEL_WIDTH    = rmfb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT   = rmfb_pkg::PANEL_HEIGHT_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [rmfb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rmfb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire rmfb_pkg::item_t                     item,
    input  wire rmfb_pkg::ctrl_cmd_t                 cmd,
    output rmfb_pkg::dp_status_t                     status,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic [7:0]                               out_read_data,
    output logic                                     out_index_invalid
);

    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int CMP_W       = ((AW > 12) ? AW : 12) + 1;
    localparam int CW          = rmfb_pkg::COORD_W;

    localparam logic signed [CW-1:0] LW_S = CW'(LOGICAL_WIDTH);
    localparam logic signed [CW-1:0] LH_S = CW'(LOGICAL_HEIGHT);
    localparam logic signed [CW-1:0] PW_S = CW'(PANEL_WIDTH);
    localparam logic signed [CW-1:0] PH_S = CW'(PANEL_HEIGHT);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(STORE_BYTES - 1);

    // Configuration registers.
    logic signed [10:0] origin_x_reg, origin_y_reg;
    logic [7:0]         size_reg;
    logic [3:0]         scale_reg;

    // Captured item and walker state.
    rmfb_pkg::item_t    item_reg;
    logic [2:0]         bit_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic signed [CW-1:0] x0_reg, cur_x_reg, cur_y_reg;
    logic [8:0]         w_reg, rem_x_reg, rem_y_reg;
    logic [AW-1:0]      wr_addr_reg;
    logic [7:0]         wr_mask_reg;

    // Frame memory.
    logic [7:0]         mem [STORE_BYTES];
    logic [7:0]         mem_rdata_reg;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [7:0]         mem_wdata;

    // Result register.
    logic               out_valid_reg;
    logic [7:0]         out_data_reg;
    logic               out_invalid_reg;

    // Pixel address.
    logic signed [CW-1:0] py;
    logic               in_logical, in_panel;
    logic [AW-1:0]      pix_addr;
    logic [7:0]         pix_mask;

    // Bitmap bit.
    logic [7:0]         rx;
    logic [11:0]        rx_scaled, ry_scaled;
    logic signed [CW-1:0] sq_x, sq_y;
    logic               bit_set;

    // Read index.
    logic [CMP_W-1:0]   ridx_ext;
    logic               idx_ok;
    logic               is_read;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            size_reg     <= 8'd1;
            scale_reg    <= 4'd1;
        end
        else if (cfg_wr_en)
        begin
            case (rmfb_pkg::cfg_reg_t'(cfg_index))
                rmfb_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                rmfb_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                rmfb_pkg::CFG_SIZE:     size_reg     <= cfg_data[7:0];
                rmfb_pkg::CFG_SCALE:    scale_reg    <= cfg_data[3:0];
                default:                size_reg     <= size_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
    end

    // Clear sweep address wraps to zero, ready for the next clear; the bitmap bit counter restarts on capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            bit_reg      <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : clr_addr_reg + 1'b1;
            end
            if (cmd.capture)
            begin
                bit_reg <= '0;
            end
            else if (cmd.bit_step)
            begin
                bit_reg <= bit_reg + 1'b1;
            end
        end
    end

    // Bitmap square placement for the current bit.
    assign rx        = {item_reg.source_column, bit_reg};
    assign rx_scaled = 12'(rx) * 12'(scale_reg);
    assign ry_scaled = 12'(item_reg.source_row) * 12'(scale_reg);
    assign sq_x      = {{(CW-11){origin_x_reg[10]}}, origin_x_reg} + CW'(rx_scaled);
    assign sq_y      = {{(CW-11){origin_y_reg[10]}}, origin_y_reg} + CW'(ry_scaled);
    assign bit_set   = item_reg.source_byte[rmfb_pkg::LAST_BIT - bit_reg];

    // Span walker: x runs inside, y outside.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_x_reg <= '0;
            rem_y_reg <= '0;
        end
        else if (cmd.span_load_item)
        begin
            if (item_reg.action == rmfb_pkg::ACT_PIXEL)
            begin
                rem_x_reg <= 9'd1;
                rem_y_reg <= 9'd1;
            end
            else
            begin
                rem_x_reg <= item_reg.rect_width;
                rem_y_reg <= item_reg.rect_height;
            end
        end
        else if (cmd.span_load_square)
        begin
            rem_x_reg <= 9'(scale_reg);
            rem_y_reg <= 9'(scale_reg);
        end
        else if (cmd.span_step)
        begin
            if (rem_x_reg != 9'd1)
            begin
                rem_x_reg <= rem_x_reg - 1'b1;
            end
            else
            begin
                rem_x_reg <= w_reg;
                rem_y_reg <= rem_y_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.span_load_item)
        begin
            x0_reg    <= {{(CW-11){item_reg.pos_x[10]}}, item_reg.pos_x};
            cur_x_reg <= {{(CW-11){item_reg.pos_x[10]}}, item_reg.pos_x};
            cur_y_reg <= {{(CW-11){item_reg.pos_y[10]}}, item_reg.pos_y};
            w_reg     <= (item_reg.action == rmfb_pkg::ACT_PIXEL) ? 9'd1
                                                                  : item_reg.rect_width;
        end
        else if (cmd.span_load_square)
        begin
            x0_reg    <= sq_x;
            cur_x_reg <= sq_x;
            cur_y_reg <= sq_y;
            w_reg     <= 9'(scale_reg);
        end
        else if (cmd.span_step)
        begin
            if (rem_x_reg != 9'd1)
            begin
                cur_x_reg <= cur_x_reg + 1'b1;
            end
            else
            begin
                cur_x_reg <= x0_reg;
                cur_y_reg <= cur_y_reg + 1'b1;
            end
        end
    end

    // Rotation and clipping: panel column is logical y, panel row is width-1-x.
    assign py         = LW_S - CW'(1) - cur_x_reg;
    assign in_logical = (cur_x_reg >= 0) && (cur_x_reg < LW_S)
                     && (cur_y_reg >= 0) && (cur_y_reg < LH_S);
    assign in_panel   = (cur_y_reg < PW_S) && (py < PH_S);
    assign pix_addr   = AW'($unsigned(py)) * AW'(ROW_BYTES)
                      + AW'($unsigned(cur_y_reg) >> 3);
    assign pix_mask   = rmfb_pkg::PIX_MASK_MSB >> cur_y_reg[2:0];

    always_ff @(posedge clk)
    begin
        if (cmd.pix_rd)
        begin
            wr_addr_reg <= pix_addr;
            wr_mask_reg <= pix_mask;
        end
    end

    // Read index check.
    assign ridx_ext = CMP_W'(item_reg.read_index);
    assign idx_ok   = ridx_ext < CMP_W'(STORE_BYTES);
    assign is_read  = (item_reg.action == rmfb_pkg::ACT_READ);

    // Memory port selection.
    always_comb
    begin
        mem_we    = cmd.clr_wr || cmd.pix_wr;
        mem_re    = cmd.pix_rd || cmd.rd_issue;
        mem_waddr = cmd.clr_wr ? clr_addr_reg : wr_addr_reg;
        mem_raddr = cmd.pix_rd ? pix_addr : ridx_ext[AW-1:0];
        if (cmd.clr_wr)
        begin
            mem_wdata = rmfb_pkg::BYTE_WHITE;
        end
        else if (item_reg.ink_black || item_reg.action == rmfb_pkg::ACT_BITMAP)
        begin
            mem_wdata = mem_rdata_reg & ~wr_mask_reg;
        end
        else
        begin
            mem_wdata = mem_rdata_reg | wr_mask_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_data_reg    <= (is_read && idx_ok) ? mem_rdata_reg : 8'd0;
            out_invalid_reg <= is_read && !idx_ok;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_read_data     = out_data_reg;
    assign out_index_invalid = out_invalid_reg;

    assign status.clr_last    = (clr_addr_reg == LAST_ADDR);
    assign status.span_empty  = (rem_x_reg == 9'd0) || (rem_y_reg == 9'd0);
    assign status.span_last   = (rem_x_reg == 9'd1) && (rem_y_reg == 9'd1);
    assign status.pix_in_clip = in_logical && in_panel;
    assign status.bit_paints  = bit_set && (rx < size_reg) && (item_reg.source_row < size_reg);
    assign status.bit_last    = (bit_reg == rmfb_pkg::LAST_BIT);
    assign status.out_free    = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

/* src/rotated_mono_framebuffer_blitter.sv */
// Top level of the rotated monochrome framebuffer blitter.
`default_nettype none

// The block keeps a one-bit-per-pixel frame (1 white, 0 black) in panel order, rows of
// (PANEL_WIDTH+7)/8 bytes, MSB first, and takes one action per input transfer: clear to
// white, set a pixel, fill a rectangle, blit one bitmap byte, or read a byte. Logical
// coordinates are turned 270 degrees onto the panel (panel column = y, panel row =
// LOGICAL_WIDTH-1-x); anything off the logical or panel area is dropped. Every input
// transfer yields exactly one output transfer: the byte and an invalid flag for a read,
// zeros otherwise. All pixel work goes through one single-port-per-direction frame memory
// as a read-modify-write, so timing is set by that memory port: a painted pixel is read
// and then written, a clipped one is only stepped over. A rectangle walks each of its
// pixels, and a bitmap byte walks its eight bits, painting a scale-by-scale square for
// each set bit inside the bitmap size. A clear sweeps the memory one byte a cycle over
// all (PANEL_WIDTH+7)/8*PANEL_HEIGHT bytes (4000 by default) and then gives its result.
// The same clearing pass runs after reset, and no input transfer is taken until it has
// finished; configuration writes are taken at any time but belong between items. A
// finished result sits in an output register, so the next input transfer is taken while
// it waits.

module rotated_mono_framebuffer_blitter
#(
    parameter int LOGICAL_WIDTH  = rmfb_pkg::LOGICAL_WIDTH_DEF,
    parameter int LOGICAL_HEIGHT = rmfb_pkg::LOGICAL_HEIGHT_DEF,
    parameter int PANEL_WIDTH    = rmfb_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT   = rmfb_pkg::PANEL_HEIGHT_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration: 0 origin x, 1 origin y, 2 bitmap size, 3 scale.
    input  wire logic                                cfg_wr_en,
    input  wire logic [rmfb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rmfb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // pos_x[10:0], pos_y[21:11], rect_width[30:22], rect_height[39:31], ink_black[40],
    // source_byte[48:41], source_row[56:49], source_column[61:57], read_index[73:62], zero pad
    input  wire logic [rmfb_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    // action[2:0]
    input  wire logic [rmfb_pkg::TUSER_IN_W-1:0]     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // read_data[7:0]
    output logic [rmfb_pkg::TDATA_OUT_W-1:0]         m_axis_tdata,
    // index_invalid[0]
    output logic [0:0]                               m_axis_tuser
);

    rmfb_pkg::item_t      item;
    rmfb_pkg::ctrl_cmd_t  cmd;
    rmfb_pkg::dp_status_t status;
    logic                 index_invalid;

    // Unpack the input transfer into its fields.
    assign item.action        = s_axis_tuser[2:0];
    assign item.pos_x         = s_axis_tdata[10:0];
    assign item.pos_y         = s_axis_tdata[21:11];
    assign item.rect_width    = s_axis_tdata[30:22];
    assign item.rect_height   = s_axis_tdata[39:31];
    assign item.ink_black     = s_axis_tdata[40];
    assign item.source_byte   = s_axis_tdata[48:41];
    assign item.source_row    = s_axis_tdata[56:49];
    assign item.source_column = s_axis_tdata[61:57];
    assign item.read_index    = s_axis_tdata[73:62];

    rmfb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser[2:0]),
        .in_ready  (s_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rmfb_datapath
    #(
        .LOGICAL_WIDTH  (LOGICAL_WIDTH),
        .LOGICAL_HEIGHT (LOGICAL_HEIGHT),
        .PANEL_WIDTH    (PANEL_WIDTH),
        .PANEL_HEIGHT   (PANEL_HEIGHT)
    )
    u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .item              (item),
        .cmd               (cmd),
        .status            (status),
        .out_ready         (m_axis_tready),
        .out_valid         (m_axis_tvalid),
        .out_read_data     (m_axis_tdata),
        .out_index_invalid (index_invalid)
    );

    assign m_axis_tuser[0] = index_invalid;

    // An invalid read never carries data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("invalid read with nonzero data");

    // The block is not ready again in the cycle after an input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous item still in work");

    // The memory sees at most one access command per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_wr, cmd.pix_wr, cmd.pix_rd, cmd.rd_issue}))
        else $error("conflicting frame memory commands");

    // A result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote a pending output");

endmodule

`default_nettype wire
